>>> sv/ps2mct_pkg.sv
// Shared types, constants and helper functions for the PS/2 cursor tracker.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package ps2mct_pkg;

   localparam int COORD_BITS     = 13;
   localparam int COORD_MAX      = (2 ** COORD_BITS) - 1;
   localparam int SIZE_BITS      = 14;
   localparam int LEN_BITS       = 3;
   localparam int CSR_DATA_BITS  = 14;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SUM_BITS       = 34;
   localparam int COUNT_BITS     = 64;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(1920);
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(1080);

   // packet byte 0 bits
   localparam int SYNC_BIT    = 3;
   localparam int X_SIGN_BIT  = 4;
   localparam int Y_SIGN_BIT  = 5;
   localparam logic [7:0] BTN_MASK = 8'h07;

   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_ABS  = 2'd1,
      CMD_REL  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_PACKET_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_limit;
      logic [COORD_BITS-1:0] y_limit;
      logic                  wheel_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic               from_aux;
      logic [7:0]         data_byte;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic [7:0]         button_bits;
   } item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic [7:0]            buttons;
      logic [COUNT_BITS-1:0] event_count;
      logic                  updated;
      logic                  key_valid;
      logic [7:0]            key_byte;
   } result_type;

   // largest coordinate for a screen dimension; zero size pins it to 0
   function automatic logic [COORD_BITS-1:0] axis_limit(input logic [SIZE_BITS-1:0] size);
      int m;
      m = int'(size) - 1;
      if (m < 0) begin
         return '0;
      end
      if (m > COORD_MAX) begin
         return COORD_BITS'(COORD_MAX);
      end
      return m[COORD_BITS-1:0];
   endfunction

   // clamp a wide signed sum into [0, hi]
   function automatic logic [COORD_BITS-1:0] fit_axis(input logic signed [SUM_BITS-1:0] v,
                                                      input logic [COORD_BITS-1:0] hi);
      logic signed [SUM_BITS-1:0] hi_s;
      hi_s = signed'({{(SUM_BITS - COORD_BITS){1'b0}}, hi});
      if (v < 0) begin
         return '0;
      end
      if (v > hi_s) begin
         return hi;
      end
      return v[COORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/ps2mct_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ps2mct_pkg for the coordinate and counter widths.
`default_nettype none

interface ps2mct_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic               from_aux;
   logic [7:0]         data_byte;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic [7:0]         button_bits;

   modport source (output valid, cmd, from_aux, data_byte, coord_x, coord_y, button_bits,
                   input ready);
   modport sink   (input valid, cmd, from_aux, data_byte, coord_x, coord_y, button_bits,
                   output ready);
endinterface

interface ps2mct_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ps2mct_pkg::COORD_BITS-1:0]   cursor_x;
   logic [ps2mct_pkg::COORD_BITS-1:0]   cursor_y;
   logic [7:0]                          buttons;
   logic [ps2mct_pkg::COUNT_BITS-1:0]   event_count;
   logic                                updated;
   logic                                key_valid;
   logic [7:0]                          key_byte;

   modport source (output valid, cursor_x, cursor_y, buttons, event_count, updated,
                   key_valid, key_byte,
                   input ready);
   modport sink   (input valid, cursor_x, cursor_y, buttons, event_count, updated,
                   key_valid, key_byte,
                   output ready);
endinterface

`default_nettype wire

>>> sv/ps2mct_csr.sv
// Configuration registers: screen limits and packet length mode.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ps2mct_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output ps2mct_pkg::cfg_type                        cfg
);

   ps2mct_pkg::cfg_type cfg_ff, cfg_in;

   // keep the derived limit, not the raw size
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ps2mct_pkg::csr_index_type'(csr_index))
            ps2mct_pkg::CSR_SCREEN_WIDTH:
               cfg_in.x_limit = ps2mct_pkg::axis_limit(
                  csr_wdata[ps2mct_pkg::SIZE_BITS-1:0]);
            ps2mct_pkg::CSR_SCREEN_HEIGHT:
               cfg_in.y_limit = ps2mct_pkg::axis_limit(
                  csr_wdata[ps2mct_pkg::SIZE_BITS-1:0]);
            ps2mct_pkg::CSR_PACKET_LENGTH:
               cfg_in.wheel_mode = csr_wdata[ps2mct_pkg::LEN_BITS-1];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_limit    <= ps2mct_pkg::axis_limit(ps2mct_pkg::RESET_WIDTH);
         cfg_ff.y_limit    <= ps2mct_pkg::axis_limit(ps2mct_pkg::RESET_HEIGHT);
         cfg_ff.wheel_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/ps2mct_core.sv
// Packet assembly and cursor state: computes one item's result and commits state.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire ps2mct_pkg::item_type item,
   input  wire ps2mct_pkg::cfg_type  cfg,
   output ps2mct_pkg::result_type    result
);

   localparam int CB = ps2mct_pkg::COORD_BITS;
   localparam int SB = ps2mct_pkg::SUM_BITS;

   logic [1:0]                          pkt_idx_ff, pkt_idx_in;
   logic [7:0]                          pkt_byte_ff [3];
   logic [CB-1:0]                       pos_x_ff, pos_x_in;
   logic [CB-1:0]                       pos_y_ff, pos_y_in;
   logic [7:0]                          btn_ff, btn_in;
   logic [ps2mct_pkg::COUNT_BITS-1:0]   cnt_ff, cnt_in;

   logic                 store_en;
   logic [2:0]           pkt_count;
   logic [2:0]           pkt_len;
   logic [7:0]           dy_byte;
   logic signed [8:0]    pkt_dx, pkt_dy;
   logic signed [SB-1:0] delta_x, delta_y, sum_x, sum_y;
   logic [CB-1:0]        fit_x, fit_y;
   logic                 updated, key_valid;
   logic [7:0]           key_byte;

   // byte 2 arrives in the same transfer that finishes a 3-byte packet
   assign dy_byte = (pkt_idx_ff == 2'd2) ? item.data_byte : pkt_byte_ff[2];
   assign pkt_dx  = signed'({pkt_byte_ff[0][ps2mct_pkg::X_SIGN_BIT], pkt_byte_ff[1]});
   assign pkt_dy  = signed'({pkt_byte_ff[0][ps2mct_pkg::Y_SIGN_BIT], dy_byte});

   assign pkt_count = {1'b0, pkt_idx_ff} + 3'd1;
   assign pkt_len   = cfg.wheel_mode ? 3'd4 : 3'd3;

   // one shared adder per axis; absolute injects bypass it
   always_comb begin
      if (ps2mct_pkg::cmd_type'(item.cmd) == ps2mct_pkg::CMD_BYTE) begin
         delta_x = SB'(pkt_dx);
         delta_y = SB'(pkt_dy);
      end else begin
         delta_x = SB'(item.coord_x);
         delta_y = SB'(item.coord_y);
      end
      if (ps2mct_pkg::cmd_type'(item.cmd) == ps2mct_pkg::CMD_ABS) begin
         sum_x = delta_x;
         sum_y = delta_y;
      end else begin
         sum_x = signed'({{(SB - CB){1'b0}}, pos_x_ff}) + delta_x;
         sum_y = signed'({{(SB - CB){1'b0}}, pos_y_ff}) - delta_y;
      end
   end

   assign fit_x = ps2mct_pkg::fit_axis(sum_x, cfg.x_limit);
   assign fit_y = ps2mct_pkg::fit_axis(sum_y, cfg.y_limit);

   always_comb begin
      pkt_idx_in = pkt_idx_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      btn_in     = btn_ff;
      cnt_in     = cnt_ff;
      store_en   = 1'b0;
      updated    = 1'b0;
      key_valid  = 1'b0;
      key_byte   = 8'h00;
      unique case (ps2mct_pkg::cmd_type'(item.cmd))
         ps2mct_pkg::CMD_BYTE: begin
            if (!item.from_aux) begin
               pkt_idx_in = 2'd0;
               if (!item.data_byte[ps2mct_pkg::SYNC_BIT]) begin
                  key_valid = 1'b1;
                  key_byte  = item.data_byte;
               end
            end else if (!(pkt_idx_ff == 2'd0 && !item.data_byte[ps2mct_pkg::SYNC_BIT])) begin
               store_en = (pkt_idx_ff != 2'd3);
               if (pkt_count < pkt_len) begin
                  pkt_idx_in = pkt_count[1:0];
               end else begin
                  pkt_idx_in = 2'd0;
                  pos_x_in   = fit_x;
                  pos_y_in   = fit_y;
                  btn_in     = pkt_byte_ff[0] & ps2mct_pkg::BTN_MASK;
                  cnt_in     = cnt_ff + 64'd1;
                  updated    = 1'b1;
               end
            end
         end
         ps2mct_pkg::CMD_ABS, ps2mct_pkg::CMD_REL: begin
            pos_x_in = fit_x;
            pos_y_in = fit_y;
            btn_in   = item.button_bits;
            cnt_in   = cnt_ff + 64'd1;
            updated  = 1'b1;
         end
         default: begin
            pkt_idx_in = pkt_idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_idx_ff <= 2'd0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         btn_ff     <= 8'h00;
         cnt_ff     <= '0;
      end else if (fire) begin
         pkt_idx_ff <= pkt_idx_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         btn_ff     <= btn_in;
         cnt_ff     <= cnt_in;
      end
   end

   // packet bytes need no reset
   always_ff @(posedge clock) begin
      if (fire && store_en) begin
         pkt_byte_ff[pkt_idx_ff] <= item.data_byte;
      end
   end

   always_comb begin
      result.cursor_x    = pos_x_in;
      result.cursor_y    = pos_y_in;
      result.buttons     = btn_in;
      result.event_count = cnt_in;
      result.updated     = updated;
      result.key_valid   = key_valid;
      result.key_byte    = key_byte;
   end

`ifndef NO_ASSERTIONS
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      fire && updated |=> cnt_ff == $past(cnt_ff) + 64'd1)
      else $error("event counter did not advance on a pointer update");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      fire && !updated |=> cnt_ff == $past(cnt_ff))
      else $error("event counter moved without a pointer update");

   a_key_excl: assert property (@(posedge clock) disable iff (reset)
      key_valid |-> !updated && !item.data_byte[ps2mct_pkg::SYNC_BIT] && pkt_idx_in == 2'd0)
      else $error("keyboard byte forwarded with pointer activity");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      fire && !cfg.wheel_mode && pkt_idx_ff != 2'd3 |=> pkt_idx_ff != 2'd3)
      else $error("packet index reached 3 in 3-byte mode");
`endif

endmodule

`default_nettype wire

>>> sv/ps2mct_pipe.sv
// Input register and result register with the valid/ready control between them.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_pipe (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire ps2mct_pkg::item_type   in_item,
   output      logic                   fire,
   output ps2mct_pkg::item_type        cur_item,
   input  wire ps2mct_pkg::result_type cur_result,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output ps2mct_pkg::result_type      out_result
);

   logic                   s1_valid_ff, s1_valid_in;
   ps2mct_pkg::item_type   s1_item_ff;
   logic                   s2_valid_ff, s2_valid_in;
   ps2mct_pkg::result_type s2_result_ff;
   logic                   s2_free;
   logic                   in_xfer;

   assign s2_free  = !s2_valid_ff || out_ready;
   assign fire     = s1_valid_ff && s2_free;
   assign in_ready = !s1_valid_ff || s2_free;
   assign in_xfer  = in_valid && in_ready;

   assign s1_valid_in = in_xfer || (s1_valid_ff && !fire);
   assign s2_valid_in = fire || (s2_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         s1_item_ff <= in_item;
      end
      if (fire) begin
         s2_result_ff <= cur_result;
      end
   end

   assign cur_item   = s1_item_ff;
   assign out_valid  = s2_valid_ff;
   assign out_result = s2_result_ff;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |-> !in_ready)
      else $error("input register overwritten while occupied");

   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      fire |=> s2_valid_ff)
      else $error("result lost after leaving the input register");
`endif

endmodule

`default_nettype wire

>>> sv/ps2_mouse_packet_cursor_tracker.sv
// Top level of the PS/2 mouse packet decoder and cursor tracker.
// Depends on ps2mct_pkg, ps2mct_ifs, ps2mct_csr, ps2mct_core and ps2mct_pipe.
`default_nettype none

//  channel   dir  handshake            payload
//  req_ch    in   valid/ready          cmd, from_aux, data_byte, coord_x, coord_y,
//                                      button_bits
//  rsp_ch    out  valid/ready          cursor_x, cursor_y, buttons, event_count,
//                                      updated, key_valid, key_byte
//  csr_*     in   csr_we (no stall)    csr_index, csr_wdata
//
//  Throughput is one item per cycle while rsp_ch does not stall; each item passes the
//  input register, then the result register. The cursor, button and counter state
//  commit in the same cycle the item moves into the result register, so the next
//  item sees it at once. Reset clears the valid flags, cursor, buttons, counter and
//  packet index, and loads 1920 x 1080 with 3-byte packets. Under a response stall
//  both registers fill and req_ch.ready drops; it rises again the cycle rsp_ch is
//  drained.

module ps2_mouse_packet_cursor_tracker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   ps2mct_req_if.sink                                 req_ch,
   ps2mct_rsp_if.source                               rsp_ch,
   input  wire logic                                  csr_we,
   input  wire logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ps2mct_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   ps2mct_pkg::cfg_type    cfg;
   ps2mct_pkg::item_type   in_item;
   ps2mct_pkg::item_type   cur_item;
   ps2mct_pkg::result_type cur_result;
   ps2mct_pkg::result_type out_result;
   logic                   fire;
   logic                   in_ready;
   logic                   out_valid;

   // gather the request payload into one word
   always_comb begin
      in_item.cmd         = req_ch.cmd;
      in_item.from_aux    = req_ch.from_aux;
      in_item.data_byte   = req_ch.data_byte;
      in_item.coord_x     = req_ch.coord_x;
      in_item.coord_y     = req_ch.coord_y;
      in_item.button_bits = req_ch.button_bits;
   end

   ps2mct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // hold items and results; advance when the result register can take one
   ps2mct_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (in_ready),
      .in_item    (in_item),
      .fire       (fire),
      .cur_item   (cur_item),
      .cur_result (cur_result),
      .out_valid  (out_valid),
      .out_ready  (rsp_ch.ready),
      .out_result (out_result)
   );

   // decode the held item and commit state on fire
   ps2mct_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (cur_item),
      .cfg    (cfg),
      .result (cur_result)
   );

   assign req_ch.ready       = in_ready;
   assign rsp_ch.valid       = out_valid;
   assign rsp_ch.cursor_x    = out_result.cursor_x;
   assign rsp_ch.cursor_y    = out_result.cursor_y;
   assign rsp_ch.buttons     = out_result.buttons;
   assign rsp_ch.event_count = out_result.event_count;
   assign rsp_ch.updated     = out_result.updated;
   assign rsp_ch.key_valid   = out_result.key_valid;
   assign rsp_ch.key_byte    = out_result.key_byte;

`ifndef NO_ASSERTIONS
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.updated && rsp_ch.key_valid))
      else $error("response flags both a pointer update and a key byte");

   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.key_valid |-> rsp_ch.key_byte == 8'h00)
      else $error("key byte set without key_valid");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.updated && $stable(cfg) |->
         rsp_ch.cursor_x <= cfg.x_limit && rsp_ch.cursor_y <= cfg.y_limit)
      else $error("updated cursor outside the screen");
`endif

endmodule

`default_nettype wire
